FILE: rtl/rolbl_pkg.sv
// ----------------------------------------------------------------------------
// rolbl_pkg
// Shared types and constants of the range overlap bad lag marker.
// ----------------------------------------------------------------------------
package rolbl_pkg;

  localparam int ADDR_W = 5;

  localparam logic [2:0] REG_TAU        = 3'd0;
  localparam logic [2:0] REG_NAVE       = 3'd1;
  localparam logic [2:0] REG_NRANG      = 3'd2;
  localparam logic [2:0] REG_NUM_PULSES = 3'd3;
  localparam logic [2:0] REG_NUM_LAGS   = 3'd4;

  // floor(x / 10) for x below 4096 as (x * RATIO_MUL) >> RATIO_SHIFT.
  localparam logic [23:0] RATIO_MUL   = 24'd3277;
  localparam int          RATIO_SHIFT = 15;

  typedef enum logic [1:0] {
    CMD_PULSE = 2'd0,
    CMD_LAG   = 2'd1,
    CMD_POWER = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [7:0] tau;
    logic [8:0] ratio;
    logic [8:0] nrang;
    logic [4:0] num_pulses;
    logic [5:0] num_lags;
  } cfg_t;

  typedef struct packed {
    logic [31:0] bad_lag_mask;
    logic [15:0] bad_pulse_mask;
    logic        range_error;
  } res_t;

endpackage

FILE: rtl/rolbl_cfg.sv
// ----------------------------------------------------------------------------
// rolbl_cfg
// Configuration registers behind the register port, with the power ratio.
// ----------------------------------------------------------------------------
module rolbl_cfg import rolbl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [7:0]  tau_q;
  logic [9:0]  nave_q;
  logic [8:0]  ratio_q;
  logic [8:0]  ratio_d;
  logic [8:0]  nrang_q;
  logic [4:0]  num_pulses_q;
  logic [5:0]  num_lags_q;
  logic        wr;
  logic [11:0] nave3;
  logic [23:0] ratio_prod;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;

  assign nave3      = 12'({2'b00, pwdata[9:0]} * 12'd3);
  assign ratio_prod = {12'b0, nave3} * RATIO_MUL;
  assign ratio_d    = ratio_prod[RATIO_SHIFT+8:RATIO_SHIFT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tau_q        <= 8'd1;
      nave_q       <= '0;
      ratio_q      <= '0;
      nrang_q      <= '0;
      num_pulses_q <= '0;
      num_lags_q   <= '0;
    end else if (wr) begin
      unique case (paddr[4:2])
        REG_TAU:        tau_q <= pwdata[7:0];
        REG_NAVE: begin
          nave_q  <= pwdata[9:0];
          ratio_q <= ratio_d;
        end
        REG_NRANG:      nrang_q <= pwdata[8:0];
        REG_NUM_PULSES: num_pulses_q <= pwdata[4:0];
        REG_NUM_LAGS:   num_lags_q <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      REG_TAU:        prdata = {24'b0, tau_q};
      REG_NAVE:       prdata = {22'b0, nave_q};
      REG_NRANG:      prdata = {23'b0, nrang_q};
      REG_NUM_PULSES: prdata = {27'b0, num_pulses_q};
      REG_NUM_LAGS:   prdata = {26'b0, num_lags_q};
      default:        prdata = '0;
    endcase
  end

  assign cfg_o.tau        = tau_q;
  assign cfg_o.ratio      = ratio_q;
  assign cfg_o.nrang      = nrang_q;
  assign cfg_o.num_pulses = num_pulses_q;
  assign cfg_o.num_lags   = num_lags_q;

endmodule

FILE: rtl/rolbl_core.sv
// ----------------------------------------------------------------------------
// rolbl_core
// Table and power memories with the query sequencer and its read pipeline.
// ----------------------------------------------------------------------------
module rolbl_core import rolbl_pkg::*; #(
  parameter int MAX_PULSES = 16,
  parameter int MAX_LAGS   = 32,
  parameter int MAX_RANGES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  slot_i,
  input  logic        lag_side_i,
  input  logic [5:0]  position_i,
  input  logic [31:0] power_i,
  input  logic [8:0]  range_number_i,
  output logic        res_valid_o,
  input  logic        res_taken_i,
  output res_t        res_o
);

  localparam int TBL_DEPTH = MAX_PULSES + 2 * MAX_LAGS;
  localparam int TAW       = $clog2(TBL_DEPTH);
  localparam int RAW       = $clog2(MAX_RANGES);
  localparam int PIW       = $clog2(MAX_PULSES);
  localparam int LIW       = (MAX_LAGS > 1) ? $clog2(MAX_LAGS) : 1;
  localparam int OUT_P     = (MAX_PULSES < 16) ? MAX_PULSES : 16;
  localparam int OUT_L     = (MAX_LAGS < 32) ? MAX_LAGS : 32;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MINP,
    S_AREAD,
    S_BLOOP,
    S_DRAIN,
    S_MARK,
    S_LAGS,
    S_LFLUSH,
    S_DONE
  } state_e;

  state_e state_q;

  logic [5:0]  tbl_mem [TBL_DEPTH];
  logic [31:0] pwr_mem [MAX_RANGES];
  logic [5:0]  tbl_rdata_q;
  logic [31:0] pwr_rdata_q;
  logic [TAW-1:0] tbl_waddr;
  logic [TAW-1:0] tbl_raddr;
  logic [RAW-1:0] pwr_raddr;
  logic        tbl_we;
  logic        pwr_we;

  logic [4:0]  np;
  logic [5:0]  nl;
  logic [8:0]  nr;
  logic        acc;
  cmd_e        cmd;
  logic        q_bad;
  logic [8:0]  base_in;

  logic [4:0]  a_q;
  logic [4:0]  b_q;
  logic [5:0]  k_q;
  logic        side_q;
  logic        posa_ld_q;
  logic        s1_valid_q;
  logic        s2_valid_q;
  logic        s3_valid_q;
  logic        m_valid_q;
  logic        l_valid_q;
  logic        err_q;
  logic [MAX_PULSES-1:0] pmask_q;
  logic [MAX_LAGS-1:0]   lmask_q;

  logic [8:0]     base_q;
  logic [40:0]    min_pwr_q;
  logic [5:0]     posa_q;
  logic [16:0]    g_q;
  logic [PIW-1:0] s1_tag_q;
  logic [PIW-1:0] s2_tag_q;
  logic [PIW-1:0] s3_tag_q;
  logic [LIW-1:0] l_tag_q;
  logic [63:0]    bad_pos_q;

  logic [6:0]  diff;
  logic [15:0] prod;
  logic [16:0] g_d;
  logic        g_in_rng;
  logic        pwr_gt;
  logic [40:0] min_pwr_d;

  assign np = (cfg_i.num_pulses > MAX_PULSES) ? 5'(MAX_PULSES) : cfg_i.num_pulses;
  assign nl = (cfg_i.num_lags > MAX_LAGS) ? 6'(MAX_LAGS) : cfg_i.num_lags;
  assign nr = (cfg_i.nrang > MAX_RANGES) ? 9'(MAX_RANGES) : cfg_i.nrang;

  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i & in_ready_o;
  assign cmd        = cmd_e'(cmd_i);
  assign q_bad      = (range_number_i == 9'd0) || (range_number_i > nr);
  assign base_in    = range_number_i - 9'd1;

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = TAW'(slot_i);
    pwr_we    = 1'b0;
    if (acc) begin
      unique case (cmd)
        CMD_PULSE: tbl_we = (int'(slot_i) < MAX_PULSES);
        CMD_LAG: begin
          tbl_we    = (int'(slot_i) < MAX_LAGS);
          tbl_waddr = TAW'(MAX_PULSES) + (lag_side_i ? TAW'(MAX_LAGS) : '0) + TAW'(slot_i);
        end
        CMD_POWER: pwr_we = (int'(slot_i) < MAX_RANGES);
        CMD_QUERY: ;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (state_q)
      S_BLOOP: tbl_raddr = TAW'(b_q);
      S_LAGS:  tbl_raddr = TAW'(MAX_PULSES) + (side_q ? TAW'(MAX_LAGS) : '0) + TAW'(k_q);
      default: tbl_raddr = TAW'(a_q);
    endcase
  end

  assign pwr_raddr = (state_q == S_IDLE) ? RAW'(base_in) : RAW'(g_q[15:0]);

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= position_i;
    end
    tbl_rdata_q <= tbl_mem[tbl_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pwr_we) begin
      pwr_mem[RAW'(slot_i)] <= power_i;
    end
    pwr_rdata_q <= pwr_mem[pwr_raddr];
  end

  assign diff      = {1'b0, posa_q} - {1'b0, tbl_rdata_q};
  assign prod      = {{9{diff[6]}}, diff} * {8'b0, cfg_i.tau};
  assign g_d       = {8'b0, base_q} + {prod[15], prod};
  assign g_in_rng  = !g_q[16] && (g_q[15:0] < {7'b0, nr});
  assign pwr_gt    = ({9'b0, pwr_rdata_q} > min_pwr_q);
  assign min_pwr_d = {32'b0, cfg_i.ratio} * {9'b0, pwr_rdata_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      a_q        <= '0;
      b_q        <= '0;
      k_q        <= '0;
      side_q     <= 1'b0;
      posa_ld_q  <= 1'b0;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
      l_valid_q  <= 1'b0;
      err_q      <= 1'b0;
      pmask_q    <= '0;
      lmask_q    <= '0;
    end else begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q && g_in_rng;
      posa_ld_q  <= 1'b0;
      m_valid_q  <= 1'b0;
      l_valid_q  <= 1'b0;
      if (s3_valid_q && pwr_gt) begin
        pmask_q[s3_tag_q] <= 1'b1;
      end
      if (l_valid_q && bad_pos_q[tbl_rdata_q]) begin
        lmask_q[l_tag_q] <= 1'b1;
      end
      unique case (state_q)
        S_IDLE: begin
          if (acc && (cmd == CMD_QUERY)) begin
            pmask_q <= '0;
            lmask_q <= '0;
            err_q   <= q_bad;
            a_q     <= '0;
            state_q <= q_bad ? S_DONE : S_MINP;
          end
        end
        S_MINP: state_q <= S_AREAD;
        S_AREAD: begin
          if (a_q >= np) begin
            state_q <= S_DRAIN;
          end else begin
            posa_ld_q <= 1'b1;
            b_q       <= '0;
            state_q   <= S_BLOOP;
          end
        end
        S_BLOOP: begin
          s1_valid_q <= (b_q != a_q);
          b_q        <= b_q + 5'd1;
          if (b_q == np - 5'd1) begin
            a_q     <= a_q + 5'd1;
            state_q <= S_AREAD;
          end
        end
        S_DRAIN: begin
          if (!s1_valid_q && !s2_valid_q && !s3_valid_q) begin
            a_q     <= '0;
            state_q <= S_MARK;
          end
        end
        S_MARK: begin
          if (a_q >= np) begin
            k_q     <= '0;
            side_q  <= 1'b0;
            state_q <= S_LAGS;
          end else begin
            m_valid_q <= pmask_q[a_q[PIW-1:0]];
            a_q       <= a_q + 5'd1;
          end
        end
        S_LAGS: begin
          if (nl == 6'd0) begin
            state_q <= S_DONE;
          end else begin
            l_valid_q <= 1'b1;
            k_q       <= k_q + 6'd1;
            if (k_q == nl - 6'd1) begin
              k_q <= '0;
              if (side_q) begin
                state_q <= S_LFLUSH;
              end else begin
                side_q <= 1'b1;
              end
            end
          end
        end
        S_LFLUSH: state_q <= S_DONE;
        S_DONE: begin
          if (res_taken_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      base_q <= base_in;
    end
    if (state_q == S_MINP) begin
      min_pwr_q <= min_pwr_d;
    end
    if (posa_ld_q) begin
      posa_q <= tbl_rdata_q;
    end
    s1_tag_q <= a_q[PIW-1:0];
    s2_tag_q <= s1_tag_q;
    s3_tag_q <= s2_tag_q;
    g_q      <= g_d;
    l_tag_q  <= k_q[LIW-1:0];
    if (state_q == S_DRAIN) begin
      bad_pos_q <= '0;
    end else if (m_valid_q) begin
      bad_pos_q[tbl_rdata_q] <= 1'b1;
    end
  end

  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    res_o             = '0;
    res_o.range_error = err_q;
    for (int i = 0; i < OUT_P; i++) begin
      res_o.bad_pulse_mask[i] = pmask_q[i];
    end
    for (int i = 0; i < OUT_L; i++) begin
      res_o.bad_lag_mask[i] = lmask_q[i];
    end
  end

  a_mark_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MARK) |-> (!s1_valid_q && !s2_valid_q && !s3_valid_q))
    else $error("Pair pipeline still busy while marking bad positions.");

  a_error_zero_masks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && err_q) |-> ((pmask_q == '0) && (lmask_q == '0)))
    else $error("Range error result carries nonzero masks.");

  a_no_self_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> ($past(b_q) != $past(a_q)))
    else $error("Pulse compared against itself.");

  a_power_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid_q |-> (int'($past(g_q[15:0])) < MAX_RANGES))
    else $error("Offset gate read outside the power memory.");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!s1_valid_q && !s2_valid_q && !s3_valid_q && !l_valid_q))
    else $error("Word accepted while the read pipeline is busy.");

endmodule

FILE: rtl/range_overlap_bad_lag_marker_unit.sv
// ----------------------------------------------------------------------------
// range_overlap_bad_lag_marker_unit
// Marks pulses and lags disturbed by echoes from overlapping range gates.
// ----------------------------------------------------------------------------
// The input channel carries one command word per handshake: pulse position
// loads, lag table loads and power loads give no result. A query word names a
// 1-based range gate and gives one result word with the bad lag mask, the bad
// pulse mask and a range error flag. The run time of a query is set by the
// single read port of the table memory, which is read once per ordered pulse
// pair, twice per pulse and once per lag entry, on both lag sides.
// A query outside 1..nrang skips the search and gives zero masks and a set
// range error flag. The result sits in an output register; a new word is
// accepted while it waits, and a second query holds its result until the
// register frees. Reset clears the registers to their defaults and stops any
// query; the tables hold no valid data until loaded. Configuration must be
// written through the register port while the block is idle; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module range_overlap_bad_lag_marker_unit import rolbl_pkg::*; #(
  parameter int MAX_PULSES = 16,
  parameter int MAX_LAGS   = 32,
  parameter int MAX_RANGES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        cmd_i,
  input  logic [7:0]        slot_i,
  input  logic              lag_side_i,
  input  logic [5:0]        position_i,
  input  logic [31:0]       power_i,
  input  logic [8:0]        range_number_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [31:0]       bad_lag_mask_o,
  output logic [15:0]       bad_pulse_mask_o,
  output logic              range_error_o
);

  cfg_t cfg;
  res_t res;
  logic res_valid;
  logic res_taken;
  logic out_valid_q;
  res_t out_q;

  rolbl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rolbl_core #(
    .MAX_PULSES (MAX_PULSES),
    .MAX_LAGS   (MAX_LAGS),
    .MAX_RANGES (MAX_RANGES)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .slot_i         (slot_i),
    .lag_side_i     (lag_side_i),
    .position_i     (position_i),
    .power_i        (power_i),
    .range_number_i (range_number_i),
    .res_valid_o    (res_valid),
    .res_taken_i    (res_taken),
    .res_o          (res)
  );

  assign res_taken = res_valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= res_taken || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_taken) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign bad_lag_mask_o   = out_q.bad_lag_mask;
  assign bad_pulse_mask_o = out_q.bad_pulse_mask;
  assign range_error_o    = out_q.range_error;

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the range overlap bad lag marker unit.
// ----------------------------------------------------------------------------
// The tables are filled first. A short directed run then covers the edges of
// the fields, and several register settings follow with random words. Each
// query word is predicted when it is accepted, and every result word is
// compared against the oldest prediction. Both channels stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import rolbl_pkg::*;

  localparam int P_MAX         = 16;
  localparam int L_MAX         = 32;
  localparam int R_MAX         = 256;
  localparam int SETTLE_CYCLES = 400;
  localparam int DRAIN_LIMIT   = 50000;
  localparam int CYCLE_LIMIT   = 4000000;

  typedef struct {
    cmd_e        cmd;
    logic [7:0]  slot;
    logic        side;
    logic [5:0]  pos;
    logic [31:0] pwr;
    logic [8:0]  rnum;
  } cmd_word_t;

  logic              clk_i            = 1'b0;
  logic              rst_ni           = 1'b0;
  logic              psel             = 1'b0;
  logic              penable          = 1'b0;
  logic              pwrite           = 1'b0;
  logic [ADDR_W-1:0] paddr            = '0;
  logic [31:0]       pwdata           = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i       = 1'b0;
  logic              in_ready_o;
  logic [1:0]        cmd_i            = '0;
  logic [7:0]        slot_i           = '0;
  logic              lag_side_i       = 1'b0;
  logic [5:0]        position_i       = '0;
  logic [31:0]       power_i          = '0;
  logic [8:0]        range_number_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i      = 1'b0;
  logic [31:0]       bad_lag_mask_o;
  logic [15:0]       bad_pulse_mask_o;
  logic              range_error_o;

  logic [7:0] cfg_tau    = 8'd1;
  logic [9:0] cfg_nave   = '0;
  logic [8:0] cfg_nrang  = '0;
  logic [4:0] cfg_pulses = '0;
  logic [5:0] cfg_lags   = '0;

  logic [5:0]  pulse_tab [P_MAX];
  logic [5:0]  lag_tab   [2*L_MAX];
  logic [31:0] power_tab [R_MAX];

  cmd_word_t cmd_backlog[$];
  res_t      expected_marks[$];
  cmd_word_t next_word;

  bit word_taken = 1'b0;
  bit in_quiet   = 1'b0;
  bit out_quiet  = 1'b0;
  int in_gap     = 0;
  int out_stall  = 0;
  int mismatches = 0;
  int cycles     = 0;

  range_overlap_bad_lag_marker_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .slot_i           (slot_i),
    .lag_side_i       (lag_side_i),
    .position_i       (position_i),
    .power_i          (power_i),
    .range_number_i   (range_number_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .bad_lag_mask_o   (bad_lag_mask_o),
    .bad_pulse_mask_o (bad_pulse_mask_o),
    .range_error_o    (range_error_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_power();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'hFFFF_FFFF;
    if (r < 6) return $urandom_range(0, 1000);
    return $urandom();
  endfunction

  function automatic res_t predict_marks(logic [8:0] rnum);
    int          np;
    int          nl;
    int          nr;
    int          base;
    int          g;
    logic [63:0] ratio;
    logic [63:0] floor_pwr;
    res_t        r;
    np = (cfg_pulses > P_MAX) ? P_MAX : int'(cfg_pulses);
    nl = (cfg_lags > L_MAX) ? L_MAX : int'(cfg_lags);
    nr = (cfg_nrang > R_MAX) ? R_MAX : int'(cfg_nrang);
    r  = '0;
    if (rnum == 0 || int'(rnum) > nr) begin
      r.range_error = 1'b1;
      return r;
    end
    base      = int'(rnum) - 1;
    ratio     = (64'(cfg_nave) * 64'd3) / 64'd10;
    floor_pwr = ratio * 64'(power_tab[base]);
    for (int a = 0; a < np; a++) begin
      for (int b = 0; b < np; b++) begin
        if (a != b) begin
          g = base + (int'(pulse_tab[a]) - int'(pulse_tab[b])) * int'(cfg_tau);
          if (g >= 0 && g < nr && floor_pwr < 64'(power_tab[g])) r.bad_pulse_mask[a] = 1'b1;
        end
      end
    end
    for (int a = 0; a < np; a++) begin
      if (r.bad_pulse_mask[a]) begin
        for (int s = 0; s < 2; s++) begin
          for (int k = 0; k < nl; k++) begin
            if (lag_tab[s*L_MAX+k] == pulse_tab[a]) r.bad_lag_mask[k] = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s, got %h, expected %h", cycles, what, got, want);
    mismatches++;
  endtask

  task automatic absorb_word();
    case (cmd_e'(cmd_i))
      CMD_PULSE: if (slot_i < P_MAX) pulse_tab[slot_i[3:0]] = position_i;
      CMD_LAG:   if (slot_i < L_MAX) lag_tab[{lag_side_i, slot_i[4:0]}] = position_i;
      CMD_POWER: power_tab[slot_i] = power_i;
      default:   expected_marks.push_back(predict_marks(range_number_i));
    endcase
  endtask

  task automatic check_marks();
    res_t want;
    if (expected_marks.size() == 0) begin
      report_mismatch("result word with nothing expected", bad_lag_mask_o, '0);
    end else begin
      want = expected_marks.pop_front();
      if (bad_lag_mask_o !== want.bad_lag_mask)
        report_mismatch("bad_lag_mask", bad_lag_mask_o, want.bad_lag_mask);
      if (bad_pulse_mask_o !== want.bad_pulse_mask)
        report_mismatch("bad_pulse_mask", 32'(bad_pulse_mask_o), 32'(want.bad_pulse_mask));
      if (range_error_o !== want.range_error)
        report_mismatch("range_error", 32'(range_error_o), 32'(want.range_error));
    end
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    word_taken = rst_ni && in_valid_i && in_ready_o;
    if (word_taken) absorb_word();
    if (rst_ni && out_valid_o && out_ready_i) check_marks();
  end

  always @(negedge clk_i) begin
    if (!(in_valid_i && !word_taken)) begin
      if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap--;
      end else if (cmd_backlog.size() > 0) begin
        next_word = cmd_backlog.pop_front();
        in_valid_i     <= 1'b1;
        cmd_i          <= next_word.cmd;
        slot_i         <= next_word.slot;
        lag_side_i     <= next_word.side;
        position_i     <= next_word.pos;
        power_i        <= next_word.pwr;
        range_number_i <= next_word.rnum;
        in_gap = pick_gap(in_quiet);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (out_stall > 0) begin
      out_ready_i <= 1'b0;
      out_stall--;
    end else begin
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 2) == 0) out_stall = pick_gap(out_quiet);
    end
  end

  function automatic cmd_word_t blank_word(cmd_e c);
    cmd_word_t w;
    w.cmd  = c;
    w.slot = 8'($urandom());
    w.side = 1'($urandom());
    w.pos  = 6'($urandom());
    w.pwr  = $urandom();
    w.rnum = 9'($urandom());
    return w;
  endfunction

  task automatic push_query(logic [8:0] rnum);
    cmd_word_t w;
    w      = blank_word(CMD_QUERY);
    w.rnum = rnum;
    cmd_backlog.push_back(w);
  endtask

  task automatic push_pulse(logic [7:0] slot, logic [5:0] pos);
    cmd_word_t w;
    w      = blank_word(CMD_PULSE);
    w.slot = slot;
    w.pos  = pos;
    cmd_backlog.push_back(w);
  endtask

  task automatic push_lag(logic side, logic [7:0] slot, logic [5:0] pos);
    cmd_word_t w;
    w      = blank_word(CMD_LAG);
    w.side = side;
    w.slot = slot;
    w.pos  = pos;
    cmd_backlog.push_back(w);
  endtask

  task automatic push_power(logic [7:0] slot, logic [31:0] pwr);
    cmd_word_t w;
    w      = blank_word(CMD_POWER);
    w.slot = slot;
    w.pwr  = pwr;
    cmd_backlog.push_back(w);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_TAU:        cfg_tau    = value[7:0];
      REG_NAVE:       cfg_nave   = value[9:0];
      REG_NRANG:      cfg_nrang  = value[8:0];
      REG_NUM_PULSES: cfg_pulses = value[4:0];
      REG_NUM_LAGS:   cfg_lags   = value[5:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int t, int nv, int nr, int np, int nl);
    write_reg(REG_TAU, t);
    write_reg(REG_NAVE, nv);
    write_reg(REG_NRANG, nr);
    write_reg(REG_NUM_PULSES, np);
    write_reg(REG_NUM_LAGS, nl);
  endtask

  // Waits until every word has gone in and every result has come out, then
  // waits out the SETTLE_CYCLES margin so the block is surely idle.
  task automatic settle();
    do @(posedge clk_i);
    while (cmd_backlog.size() != 0 || in_valid_i || expected_marks.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_random_words(int count);
    int done;
    int r;
    int nr;
    nr   = (cfg_nrang > R_MAX) ? R_MAX : int'(cfg_nrang);
    done = 0;
    while (done < count) begin
      r = $urandom_range(0, 9);
      if (r < 3) begin
        r = $urandom_range(0, 9);
        if (nr == 0 || r == 0) push_query(9'($urandom_range(0, 511)));
        else if (r == 1) push_query((nr == R_MAX) ? 9'd0 : 9'(nr + 1));
        else if (r == 2) push_query(9'(nr));
        else push_query(9'($urandom_range(1, nr)));
        done++;
      end else if (r < 5) begin
        if ($urandom_range(0, 9) == 0) begin
          push_pulse(8'($urandom_range(0, 255)), 6'($urandom()));
        end else begin
          push_pulse(8'($urandom_range(0, P_MAX - 1)), 6'($urandom_range(0, 40)));
          done++;
        end
      end else if (r < 7) begin
        if ($urandom_range(0, 9) == 0) begin
          push_lag(1'($urandom()), 8'($urandom_range(0, 255)), 6'($urandom()));
        end else begin
          push_lag(1'($urandom()), 8'($urandom_range(0, L_MAX - 1)),
                   ($urandom_range(0, 3) == 0) ? 6'($urandom())
                                               : pulse_tab[$urandom_range(0, P_MAX - 1)]);
          done++;
        end
      end else begin
        push_power(8'($urandom_range(0, 255)), pick_power());
        done++;
      end
    end
  endtask

  task automatic run_phase(int t, int nv, int nr, int np, int nl, int count,
                           bit quiet_in, bit quiet_out);
    set_config(t, nv, nr, np, nl);
    in_quiet  = quiet_in;
    out_quiet = quiet_out;
    add_random_words(count);
    settle();
  endtask

  initial begin
    logic [5:0] seq_pos [P_MAX];
    int         drain;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_config(1, 10, 256, 16, 32);
    for (int i = 0; i < P_MAX; i++) begin
      seq_pos[i] = 6'($urandom_range(0, 40));
      push_pulse(8'(i), seq_pos[i]);
    end
    for (int i = 0; i < 2 * L_MAX; i++) begin
      push_lag(1'(i / L_MAX), 8'(i % L_MAX),
               ($urandom_range(0, 3) == 0) ? 6'($urandom()) : seq_pos[$urandom_range(0, 15)]);
    end
    for (int i = 0; i < R_MAX; i++) push_power(8'(i), pick_power());

    push_query(0);
    push_query(1);
    push_query(256);
    push_query(257);
    push_query(511);
    push_pulse(16, 63);
    push_pulse(255, 63);
    push_pulse(15, 63);
    push_pulse(0, 0);
    push_lag(1'b1, 32, 63);
    push_lag(1'b1, 31, 63);
    push_lag(1'b0, 0, 0);
    push_power(255, 32'hFFFF_FFFF);
    push_power(0, 32'd0);
    push_power(128, 32'hFFFF_FFFF);
    push_query(1);
    push_query(256);
    push_query(129);
    push_query(200);
    settle();

    run_phase(0, 0, 256, 16, 32, 25, 1'b0, 1'b0);
    run_phase(1, 3, 64, 8, 16, 25, 1'b1, 1'b1);
    run_phase(255, 1023, 256, 16, 32, 20, 1'b0, 1'b0);
    run_phase(2, 5, 0, 4, 4, 15, 1'b0, 1'b1);
    run_phase(3, 7, 511, 31, 63, 25, 1'b1, 1'b0);
    run_phase(1, 0, 256, 0, 0, 15, 1'b0, 1'b0);
    run_phase(2, 12, 1, 1, 1, 15, 1'b0, 1'b0);
    for (int p = 0; p < 5; p++) begin
      run_phase(($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 6),
                ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 40),
                $urandom_range(1, 256), $urandom_range(0, 16), $urandom_range(0, 32),
                20, $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
    end

    drain = 0;
    do begin
      @(posedge clk_i);
      drain++;
    end while ((cmd_backlog.size() != 0 || in_valid_i || expected_marks.size() != 0)
               && drain < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_marks.size() != 0)
      report_mismatch("expected results left over", expected_marks.size(), 0);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/rolbl_pkg.sv
rtl/rolbl_cfg.sv
rtl/rolbl_core.sv
rtl/range_overlap_bad_lag_marker_unit.sv
sim/testbench.sv
